/* design/rlm_pkg.sv */
// rlm_pkg: shared constants, types and register codes for the rms level meter
// used by every file of the block; depends on nothing

package rlm_pkg;

  // sample and accumulator geometry
  localparam int SAMPLE_BITS = 24;
  localparam int WORD_W      = 32;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int SUM_W       = 62;
  localparam int CNT_W       = 16;
  localparam int CAL_W       = 17;
  localparam int LVL_W       = 18;
  localparam int TDATA_OUT_W = ((LVL_W + 7) / 8) * 8;

  // log2 datapath
  localparam int FRAC_W   = 16;
  localparam int MANT_W   = 31;
  localparam int EXP_W    = 6;
  localparam int DIVC_W   = 6;
  localparam int LOGC_W   = 4;
  localparam int MAG_W    = EXP_W + FRAC_W;
  localparam int SCALE_W  = 26;
  localparam int PROD_W   = MAG_W + SCALE_W;
  localparam int LOG_OFS  = 2 * (SAMPLE_BITS - 1);
  localparam int RND_BIT  = 31;
  localparam int RES_LO   = 32;
  localparam int RES_W    = PROD_W + 1 - RES_LO;

  localparam logic [MAG_W-1:0]   LOG_OFS_Q16  = MAG_W'(LOG_OFS << FRAC_W);
  localparam logic [SCALE_W-1:0] DB_SCALE_Q16 = 26'd50504453;
  localparam logic [EXP_W-1:0]   EXP_TOP      = EXP_W'(SUM_W - 1);
  localparam logic [DIVC_W-1:0]  DIV_STEPS    = DIVC_W'(SUM_W - 1);
  localparam logic [LOGC_W-1:0]  LOG_STEPS    = LOGC_W'(FRAC_W - 1);

  // output constants
  localparam logic signed [LVL_W-1:0] FLOOR_DB = -18'sd51200;
  localparam logic signed [LVL_W-1:0] OUT_MAX  = 18'sh1FFFF;
  localparam logic signed [LVL_W-1:0] OUT_MIN  = 18'sh20000;

  // register reset values
  localparam logic [CNT_W-1:0] WIN_RESET = 16'd16000;
  localparam logic [CAL_W-1:0] CAL_RESET = 17'd0;

  // register indexes
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_CAL    = 1'b1;

  // one closed window handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } win_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* design/rlm_front.sv */
// rlm_front: accepts sample words, squares them and accumulates each window
// depends on rlm_pkg; pushes closed windows into rlm_queue

module rlm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rlm_pkg::WORD_W-1:0]   s_tdata,
  input  logic [rlm_pkg::CNT_W-1:0]    window_samples,
  input  rlm_pkg::q_stat_t             q_stat,
  output logic                         push,
  output rlm_pkg::win_t                push_data
);

  logic signed [rlm_pkg::SAMPLE_BITS-1:0] sample;
  logic signed [rlm_pkg::SQ_W-1:0]        sq_in;
  logic [rlm_pkg::CNT_W-1:0]              count;
  logic [rlm_pkg::CNT_W-1:0]              cnt_inc;
  logic [rlm_pkg::CNT_W-1:0]              win_eff;
  logic                                   close;
  logic                                   accept;
  logic                                   st_valid;
  logic                                   st_close;
  logic                                   st_go;
  logic [rlm_pkg::SQ_W-1:0]               sq_r;
  logic [rlm_pkg::CNT_W-1:0]              st_cnt;
  logic [rlm_pkg::SUM_W-1:0]              sum;
  logic [rlm_pkg::SUM_W-1:0]              sum_add;

  // sample from the upper bits, exact square
  assign sample = s_tdata[rlm_pkg::WORD_W-1 -: rlm_pkg::SAMPLE_BITS];
  assign sq_in  = sample * sample;

  // sample count, sticking at its top value, and window close test
  assign cnt_inc = (count == '1) ? count : count + 1'b1;
  assign win_eff = (window_samples == '0) ? rlm_pkg::CNT_W'(1) : window_samples;
  assign close   = (cnt_inc >= win_eff);

  // the accumulate stage holds only when a closing word meets a full queue
  assign st_go    = !st_close || !q_stat.full;
  assign s_tready = !st_valid || st_go;
  assign accept   = s_tvalid && s_tready;

  assign sum_add   = sum + {{(rlm_pkg::SUM_W - rlm_pkg::SQ_W){1'b0}}, sq_r};
  assign push      = st_valid && st_close && !q_stat.full;
  assign push_data = '{sum: sum_add, count: st_cnt};

  // square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      count    <= '0;
    end else if (accept) begin
      st_valid <= 1'b1;
      count    <= close ? '0 : cnt_inc;
    end else if (st_go) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r     <= sq_in;
      st_close <= close;
      st_cnt   <= cnt_inc;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (st_valid && st_go) begin
      sum <= st_close ? '0 : sum_add;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("window pushed into a full queue");
`endif

endmodule

/* design/rlm_queue.sv */
// rlm_queue: two-entry queue of closed windows between front and back
// depends on rlm_pkg

module rlm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rlm_pkg::win_t    push_data,
  input  logic             pop,
  output rlm_pkg::win_t    rd_data,
  output rlm_pkg::q_stat_t q_stat
);

  rlm_pkg::win_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign q_stat.empty = (fill == 2'd0);
  assign q_stat.full  = (fill == 2'd2);
  assign rd_data      = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* design/rlm_back.sv */
// rlm_back: divides each window sum, takes log2, scales to 1/256 dB and
// applies calibration; depends on rlm_pkg, pops windows from rlm_queue

module rlm_back (
  input  logic                               clk,
  input  logic                               rst,
  input  rlm_pkg::q_stat_t                   q_stat,
  input  rlm_pkg::win_t                      rd_data,
  output logic                               pop,
  input  logic signed [rlm_pkg::CAL_W-1:0]   calibration_offset,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rlm_pkg::TDATA_OUT_W-1:0]    m_tdata,
  output logic                               m_tuser
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_NORM  = 7'b0000100,
    ST_LOG   = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_ROUND = 7'b0100000,
    ST_FINAL = 7'b1000000
  } state_t;

  state_t                              state;
  logic [rlm_pkg::SUM_W-1:0]           quo;
  logic [rlm_pkg::CNT_W-1:0]           divisor;
  logic [rlm_pkg::CNT_W-1:0]           rem;
  logic [rlm_pkg::CNT_W:0]             shifted;
  logic                                fits;
  logic [rlm_pkg::DIVC_W-1:0]          div_cnt;
  logic [rlm_pkg::EXP_W-1:0]           expo;
  logic [rlm_pkg::MANT_W-1:0]          mant;
  logic [2*rlm_pkg::MANT_W-1:0]        msq;
  logic [rlm_pkg::LOGC_W-1:0]          log_cnt;
  logic [rlm_pkg::FRAC_W-1:0]          frac;
  logic [rlm_pkg::MAG_W-1:0]           lg;
  logic                                neg_in;
  logic [rlm_pkg::MAG_W-1:0]           mag;
  logic                                neg;
  logic [rlm_pkg::PROD_W-1:0]          prod;
  logic [rlm_pkg::PROD_W:0]            rsum;
  logic [rlm_pkg::RES_W-1:0]           rmag;
  logic signed [rlm_pkg::LVL_W-1:0]    db;
  logic                                floor_hit;
  logic signed [rlm_pkg::LVL_W:0]      lvl;
  logic signed [rlm_pkg::LVL_W-1:0]    lvl_sat;
  logic                                out_free;

  // restoring division step
  assign shifted = {rem, quo[rlm_pkg::SUM_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  // mantissa square for one fraction bit
  assign msq = mant * mant;

  // magnitude of the level relative to full scale
  assign lg     = {expo, frac};
  assign neg_in = (lg < rlm_pkg::LOG_OFS_Q16);
  assign mag    = neg_in ? (rlm_pkg::LOG_OFS_Q16 - lg) : (lg - rlm_pkg::LOG_OFS_Q16);

  // rounding half away from zero on the magnitude
  assign rsum = {1'b0, prod} + ((rlm_pkg::PROD_W + 1)'(1) << rlm_pkg::RND_BIT);
  assign rmag = rsum[rlm_pkg::PROD_W:rlm_pkg::RES_LO];

  // calibration and saturation
  assign lvl = {db[rlm_pkg::LVL_W-1], db}
             - {{(rlm_pkg::LVL_W + 1 - rlm_pkg::CAL_W){calibration_offset[rlm_pkg::CAL_W-1]}},
                calibration_offset};
  always_comb begin
    if (lvl[rlm_pkg::LVL_W] != lvl[rlm_pkg::LVL_W-1]) begin
      lvl_sat = lvl[rlm_pkg::LVL_W] ? rlm_pkg::OUT_MIN : rlm_pkg::OUT_MAX;
    end else begin
      lvl_sat = lvl[rlm_pkg::LVL_W-1:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && !q_stat.empty;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (quo == '0) begin
            state <= ST_FINAL;
          end else if (quo[rlm_pkg::SUM_W-1]) begin
            state <= ST_LOG;
          end
        end
        ST_LOG: begin
          if (log_cnt == '0) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_ROUND;
        ST_ROUND: state <= ST_FINAL;
        ST_FINAL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        quo     <= rd_data.sum;
        divisor <= rd_data.count;
        rem     <= '0;
        div_cnt <= rlm_pkg::DIV_STEPS;
        expo    <= rlm_pkg::EXP_TOP;
      end
      ST_DIV: begin
        quo     <= {quo[rlm_pkg::SUM_W-2:0], fits};
        rem     <= fits ? rlm_pkg::CNT_W'(shifted - {1'b0, divisor})
                        : shifted[rlm_pkg::CNT_W-1:0];
        div_cnt <= div_cnt - 1'b1;
      end
      ST_NORM: begin
        if (quo == '0) begin
          db        <= rlm_pkg::FLOOR_DB;
          floor_hit <= 1'b1;
        end else if (quo[rlm_pkg::SUM_W-1]) begin
          mant      <= quo[rlm_pkg::SUM_W-1 -: rlm_pkg::MANT_W];
          log_cnt   <= rlm_pkg::LOG_STEPS;
          frac      <= '0;
        end else begin
          quo       <= {quo[rlm_pkg::SUM_W-2:0], 1'b0};
          expo      <= expo - 1'b1;
        end
      end
      ST_LOG: begin
        frac    <= {frac[rlm_pkg::FRAC_W-2:0], msq[2*rlm_pkg::MANT_W-1]};
        mant    <= msq[2*rlm_pkg::MANT_W-1] ? msq[2*rlm_pkg::MANT_W-1 -: rlm_pkg::MANT_W]
                                            : msq[2*rlm_pkg::MANT_W-2 -: rlm_pkg::MANT_W];
        log_cnt <= log_cnt - 1'b1;
      end
      ST_SCALE: begin
        prod <= mag * rlm_pkg::DB_SCALE_Q16;
        neg  <= neg_in;
      end
      ST_ROUND: begin
        db        <= neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        floor_hit <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINAL && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINAL && out_free) begin
      m_tdata <= {{(rlm_pkg::TDATA_OUT_W - rlm_pkg::LVL_W){1'b0}}, lvl_sat};
      m_tuser <= floor_hit;
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (divisor != '0))
    else $error("division by a zero sample count");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("division remainder not below divisor");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == '0) |=> (state == ST_NORM))
    else $error("division did not hand over to normalise");

  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOG) |-> mant[rlm_pkg::MANT_W-1])
    else $error("log mantissa lost its leading one");
`endif

endmodule

/* design/rms_level_meter_db.sv */
// rms_level_meter_db: top level of the rms level meter with its register port
// depends on rlm_pkg, rlm_front, rlm_queue and rlm_back
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid/s_tready    s_tdata[31:0] = sample_word
// m_*       out        m_tvalid/m_tready    m_tdata[17:0] = level_db, m_tuser = floor_hit
// apb       in         psel/penable/pready  0x0 window_samples, 0x4 calibration_offset
//
// the front takes one word per cycle; it stalls only when a window closes and
// two closed windows already wait in the queue.
// each window result passes through the back's states in order: division, normalise,
// log, scale, round and final; a window whose mean is zero skips log, scale and round
// and goes from normalise straight to final. the back takes a new window only in idle.
// the back holds its last cycle for as long as the output word waits on m_tready.
// the back's serial divider and log unit set the window rate.
// reset is synchronous and clears sums, counts, queue and output valid; no
// clearing pass is needed.

module rms_level_meter_db (
  input  logic                              clk,
  input  logic                              rst,
  // input words: sample_word[31:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rlm_pkg::WORD_W-1:0]        s_tdata,
  // results: level_db[17:0], zero fill above
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rlm_pkg::TDATA_OUT_W-1:0]   m_tdata,
  // results: floor_hit[0]
  output logic                              m_tuser,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [rlm_pkg::CNT_W-1:0]         window_samples;
  logic signed [rlm_pkg::CAL_W-1:0]  calibration_offset;
  logic                              reg_sel;
  logic                              wr_en;
  logic                              push;
  logic                              pop;
  rlm_pkg::win_t                     push_data;
  rlm_pkg::win_t                     rd_data;
  rlm_pkg::q_stat_t                  q_stat;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples     <= rlm_pkg::WIN_RESET;
      calibration_offset <= rlm_pkg::CAL_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        rlm_pkg::REG_WINDOW: window_samples     <= pwdata[rlm_pkg::CNT_W-1:0];
        rlm_pkg::REG_CAL:    calibration_offset <= pwdata[rlm_pkg::CAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      rlm_pkg::REG_WINDOW: prdata = {{(32 - rlm_pkg::CNT_W){1'b0}}, window_samples};
      rlm_pkg::REG_CAL:
        prdata = {{(32 - rlm_pkg::CAL_W){calibration_offset[rlm_pkg::CAL_W-1]}},
                  calibration_offset};
      default: prdata = '0;
    endcase
  end

  // accumulate front
  rlm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .window_samples (window_samples),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  // window queue
  rlm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .q_stat    (q_stat)
  );

  // divide, log and scale back
  rlm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_stat             (q_stat),
    .rd_data            (rd_data),
    .pop                (pop),
    .calibration_offset (calibration_offset),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser)
  );

endmodule

/* tb/testbench.sv */
// testbench for rms_level_meter_db: stream words in, window levels out, apb registers
// depends on rlm_pkg and rms_level_meter_db; predicts every level and checks it in order
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_WORDS  = 540;

  // one window result: level in 1/256 db and the floor flag
  typedef struct packed {
    logic signed [rlm_pkg::LVL_W-1:0] level;
    logic                             floor_hit;
  } level_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [rlm_pkg::WORD_W-1:0]      s_tdata  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [rlm_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [2:0]                      paddr    = '0;
  logic [31:0]                     pwdata   = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  rms_level_meter_db DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state and register copies
  logic [rlm_pkg::SUM_W-1:0]        square_sum   = '0;
  logic [rlm_pkg::CNT_W-1:0]        sample_count = '0;
  logic [rlm_pkg::CNT_W-1:0]        win_reg      = rlm_pkg::WIN_RESET;
  logic signed [rlm_pkg::CAL_W-1:0] cal_reg      = rlm_pkg::CAL_RESET;

  logic [rlm_pkg::WORD_W-1:0] pending[$];
  level_t                     level_due[$];
  level_t                     due;
  int                         errors         = 0;
  logic                       in_acc         = 1'b0;
  int                         gap_left       = 0;
  int                         burst_left     = 0;
  int                         rdy_step       = 0;
  int                         stall_kind     = 0;
  logic [15:0]                stall_mask     = 16'hFFFF;
  int                         quiet          = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // log2 with 16 fraction bits, mantissa kept in q1.30
  function automatic logic [31:0] log2_frac16(input logic [63:0] m);
    logic [15:0] top;
    logic [63:0] x;
    logic [15:0] frac;
    top = '0;
    for (int b = 0; b < 64; b++)
      if (m[b]) top = 16'(b);
    x = (top >= 30) ? (m >> (top - 16'd30)) : (m << (16'd30 - top));
    frac = '0;
    for (int i = 0; i < rlm_pkg::FRAC_W; i++) begin
      x = (x * x) >> 30;
      frac = {frac[14:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    return {top, frac};
  endfunction

  // mean square to level relative to full scale, rounded half away from zero
  function automatic longint db_of_mean(input logic [63:0] mean);
    longint      l;
    logic [63:0] mag;
    logic [63:0] r;
    l = longint'(log2_frac16(mean))
      - (longint'(2 * (rlm_pkg::SAMPLE_BITS - 1)) << rlm_pkg::FRAC_W);
    mag = (l < 0) ? 64'(-l) : 64'(l);
    r = (mag * 64'd50504453 + 64'h8000_0000) >> 32;
    return (l < 0) ? -longint'(r) : longint'(r);
  endfunction

  // accumulate one accepted word, queue a level when the window closes
  task automatic accumulate_word(input logic [rlm_pkg::WORD_W-1:0] word);
    logic signed [rlm_pkg::SAMPLE_BITS-1:0] smp;
    logic [63:0]                            mean;
    logic [rlm_pkg::CNT_W-1:0]              span;
    longint                                 db;
    longint                                 lvl;
    level_t                                 res;
    smp = word[rlm_pkg::WORD_W-1 -: rlm_pkg::SAMPLE_BITS];
    square_sum = square_sum + rlm_pkg::SUM_W'(longint'(smp) * longint'(smp));
    sample_count = sample_count + 1'b1;
    if (sample_count == '0) sample_count = '1;
    span = (win_reg == '0) ? rlm_pkg::CNT_W'(1) : win_reg;
    if (sample_count >= span) begin
      mean = 64'(square_sum) / 64'(sample_count);
      res.floor_hit = (mean == 0);
      db = res.floor_hit ? longint'(rlm_pkg::FLOOR_DB) : db_of_mean(mean);
      lvl = db - longint'(cal_reg);
      if (lvl > longint'(rlm_pkg::OUT_MAX)) lvl = longint'(rlm_pkg::OUT_MAX);
      if (lvl < longint'(rlm_pkg::OUT_MIN)) lvl = longint'(rlm_pkg::OUT_MIN);
      res.level = rlm_pkg::LVL_W'(lvl);
      level_due.push_back(res);
      square_sum = '0;
      sample_count = '0;
    end
  endtask

  // apb write: setup then access, model copy follows at the write edge
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == rlm_pkg::REG_WINDOW) win_reg = value[rlm_pkg::CNT_W-1:0];
    else cal_reg = value[rlm_pkg::CAL_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_meter(input int span, input int cal);
    write_reg(rlm_pkg::REG_WINDOW, 32'(span));
    write_reg(rlm_pkg::REG_CAL, 32'(cal));
  endtask

  // wait until every word is taken and every level has come, then let the back drain
  task automatic settle();
    while (pending.size() != 0 || s_tvalid || level_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // word styles: full range, quiet (tiny samples, noisy low byte), or a mix with extremes
  function automatic logic [rlm_pkg::WORD_W-1:0] draw_word(input int style);
    int pick;
    pick = (style == 2) ? $urandom_range(0, 5) : style;
    case (pick)
      1: return {24'($signed($urandom_range(0, 6)) - 3), 8'($urandom)};
      2: return {24'h000000, 8'($urandom)};
      3: return {($urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF), 8'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_window();
    case ($urandom_range(0, 9))
      0: return 0;
      1, 2, 3, 4, 5, 6: return $urandom_range(1, 8);
      7, 8: return $urandom_range(9, 40);
      default: return $urandom_range(41, 300);
    endcase
  endfunction

  function automatic int pick_cal();
    case ($urandom_range(0, 4))
      0: return -51200;
      1: return 51200;
      2: return 0;
      default: return int'($urandom_range(0, 102400)) - 51200;
    endcase
  endfunction

  // stimulus
  initial begin
    int n;
    int random_words;
    int style;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: a part window well under 16000 words gives no level
    repeat (40) pending.push_back(draw_word(0));
    settle();

    // single word windows over the sample extremes and the ignored low byte,
    // the first one closing the part window left from the defaults
    set_meter(1, 0);
    pending.push_back(32'h0000_0000);
    pending.push_back(32'h0000_00FF);
    pending.push_back(32'h8000_0000);
    pending.push_back(32'h7FFF_FF00);
    pending.push_back(32'hFFFF_FFFF);
    pending.push_back(32'h0000_0100);
    pending.push_back(32'h5555_5555);
    pending.push_back(32'hAAAA_AAAA);
    settle();

    // zero length window acts as one, lowest calibration
    set_meter(0, -51200);
    pending.push_back(32'h0000_0000);
    pending.push_back(32'h8000_0000);
    settle();

    // mean truncating to zero hits the floor, highest calibration
    set_meter(3, 51200);
    pending.push_back(32'h0000_0100);
    pending.push_back(32'h0000_0000);
    pending.push_back(32'h0000_0000);
    settle();

    // window shortened below the count already taken closes on the next word
    write_reg(rlm_pkg::REG_WINDOW, 32'd10);
    repeat (5) pending.push_back(draw_word(0));
    settle();
    write_reg(rlm_pkg::REG_WINDOW, 32'd3);
    pending.push_back(draw_word(0));
    settle();

    // full scale negative sample gives exactly 0 db
    set_meter(2, 0);
    pending.push_back(32'h8000_0000);
    pending.push_back(32'h8000_00FF);
    settle();

    // random phases with fresh settings in between
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) write_reg(rlm_pkg::REG_WINDOW, 32'(pick_window()));
      if ($urandom_range(0, 2) == 0) write_reg(rlm_pkg::REG_CAL, 32'(pick_cal()));
      style = $urandom_range(0, 2);
      n = $urandom_range(8, 60);
      repeat (n) pending.push_back(draw_word(style));
      random_words += n;
      settle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // driver: bursts of words with random gaps, next word only after the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        s_tdata  <= pending.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern from a random kind and mask, redrawn as the run goes, sometimes always ready
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rdy_step % 48 == 0) begin
        stall_kind = $urandom_range(0, 3);
        stall_mask = 16'($urandom) | 16'h0001;
      end
      rdy_step++;
      case (stall_kind)
        0: m_tready <= 1'b1;
        1, 2: m_tready <= stall_mask[rdy_step % 16];
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on each accepted word, check each accepted level
  always @(posedge clk) begin
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) accumulate_word(s_tdata);
      if (m_tvalid && m_tready) begin
        if (level_due.size() == 0) begin
          errors++;
          $error("unexpected level word: level_db %0d floor_hit %0b",
                 $signed(m_tdata[rlm_pkg::LVL_W-1:0]), m_tuser);
        end else begin
          due = level_due.pop_front();
          if (m_tdata[rlm_pkg::LVL_W-1:0] !== due.level) begin
            errors++;
            $error("level_db: expected %0d, got %0d", due.level,
                   $signed(m_tdata[rlm_pkg::LVL_W-1:0]));
          end
          if (m_tuser !== due.floor_hit) begin
            errors++;
            $error("floor_hit: expected %0b, got %0b", due.floor_hit, m_tuser);
          end
          if (m_tdata[rlm_pkg::TDATA_OUT_W-1:rlm_pkg::LVL_W] !== '0) begin
            errors++;
            $error("tdata fill: expected 0, got %0h",
                   m_tdata[rlm_pkg::TDATA_OUT_W-1:rlm_pkg::LVL_W]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
